>>> src/fcm_pkg.sv
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types and constants of the file allocation table chain manager:
// link widths, the end-of-chain mark, operation and status codes, and the
// result record passed from the sequencer to the output register.
// ----------------------------------------------------------------------------
package fcm_pkg;

  localparam int LINK_W = 16;
  localparam int CNT_W  = 14;
  localparam int CMP_W  = LINK_W + 1;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  localparam logic [LINK_W-1:0] END_MARK  = 16'hFFFF;
  localparam logic [LINK_W-1:0] FREE_MARK = 16'h0000;

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd2;
  localparam logic [OP_W-1:0] OP_TAIL  = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd4;
  localparam logic [OP_W-1:0] OP_COUNT = 3'd5;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [ST_W-1:0] ST_LONG   = 2'd3;

  typedef struct packed {
    logic [LINK_W-1:0] index;
    logic [CNT_W-1:0]  count;
    logic [ST_W-1:0]   status;
  } fcm_result_t;

endpackage

>>> src/fcm_table.sv
// ----------------------------------------------------------------------------
// fcm_table
// Link table storage: one write port and one read port, registered read
// data, with the write data forwarded when both ports hit the same entry.
// ----------------------------------------------------------------------------
module fcm_table
  import fcm_pkg::*;
#(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [LINK_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [LINK_W-1:0] rd_data
);

  logic [LINK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Write-first: a read of the entry being written returns the new link.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/fcm_ctrl.sv
// ----------------------------------------------------------------------------
// fcm_ctrl
// Operation sequencer: clears the table after reset, then walks chains,
// searches for free entries, frees chains and counts free entries by
// reading the table one entry per cycle and writing back links.
// ----------------------------------------------------------------------------
module fcm_ctrl
  import fcm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8192,
  parameter int IDX_W         = 13,
  parameter int N_W           = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [N_W-1:0]    n_used,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [OP_W-1:0]   req_op,
  input  logic [LINK_W-1:0] req_index,
  input  logic [LINK_W-1:0] req_value,
  input  logic [LINK_W-1:0] req_head,
  output logic              done_valid,
  input  logic              res_take,
  output fcm_result_t       done_res
);

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_READ       = 4'd2;
  localparam logic [3:0] S_WALK       = 4'd3;
  localparam logic [3:0] S_SRCH_START = 4'd4;
  localparam logic [3:0] S_SEARCH     = 4'd5;
  localparam logic [3:0] S_LINK       = 4'd6;
  localparam logic [3:0] S_FREE       = 4'd7;
  localparam logic [3:0] S_COUNT      = 4'd8;
  localparam logic [3:0] S_DONE       = 4'd9;

  logic [3:0]        state, state_next;
  logic [IDX_W-1:0]  clr_addr, clr_addr_next;
  logic [OP_W-1:0]   op, op_next;
  logic              head_empty, head_empty_next;
  logic [IDX_W-1:0]  cur, cur_next;
  logic [IDX_W-1:0]  tail, tail_next;
  logic [N_W-1:0]    steps, steps_next;
  logic [N_W-1:0]    probe, probe_next;
  logic [CNT_W-1:0]  count, count_next;
  fcm_result_t       res, res_next;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [LINK_W-1:0] wr_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [LINK_W-1:0] rd_data;

  logic [CMP_W-1:0]  n_cmp;
  logic [N_W-1:0]    steps_inc;
  logic [N_W-1:0]    probe_inc;
  logic [CNT_W-1:0]  count_inc;
  logic              link_end;
  logic              link_out;
  logic              head_ok;
  logic              idx_ok;

  fcm_table #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign n_cmp     = CMP_W'(n_used);
  assign steps_inc = steps + N_W'(1);
  assign probe_inc = probe + N_W'(1);
  assign count_inc = count + CNT_W'(rd_data == FREE_MARK);
  assign link_end  = (rd_data == END_MARK);
  assign link_out  = (CMP_W'(rd_data) >= n_cmp);
  assign head_ok   = (CMP_W'(req_head) < n_cmp);
  assign idx_ok    = (CMP_W'(req_index) < n_cmp);

  assign req_ready  = (state == S_IDLE);
  assign done_valid = (state == S_DONE);
  assign done_res   = res;

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    op_next         = op;
    head_empty_next = head_empty;
    cur_next        = cur;
    tail_next       = tail;
    steps_next      = steps;
    probe_next      = probe;
    count_next      = count;
    res_next        = res;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = FREE_MARK;
    rd_addr         = '0;

    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = (clr_addr == '0) ? END_MARK : FREE_MARK;
        if (clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          op_next         = req_op;
          head_empty_next = (req_head == END_MARK);
          cur_next        = req_head[IDX_W-1:0];
          steps_next      = '0;
          probe_next      = '0;
          count_next      = '0;
          res_next.index  = END_MARK;
          res_next.count  = '0;
          res_next.status = ST_OK;
          state_next      = S_DONE;
          unique case (req_op)
            OP_WRITE: begin
              if (idx_ok) begin
                wr_en   = 1'b1;
                wr_addr = req_index[IDX_W-1:0];
                wr_data = req_value;
              end else begin
                res_next.status = ST_RANGE;
              end
            end
            OP_READ: begin
              if (idx_ok) begin
                rd_addr    = req_index[IDX_W-1:0];
                state_next = S_READ;
              end else begin
                res_next.status = ST_RANGE;
              end
            end
            OP_ALLOC, OP_TAIL: begin
              if (req_head == END_MARK) begin
                if (req_op == OP_ALLOC) begin
                  state_next = S_SRCH_START;
                end
              end else if (!head_ok) begin
                res_next.status = ST_RANGE;
              end else begin
                rd_addr    = req_head[IDX_W-1:0];
                state_next = S_WALK;
              end
            end
            OP_FREE: begin
              if (req_head != END_MARK) begin
                if (!head_ok) begin
                  res_next.status = ST_RANGE;
                end else begin
                  rd_addr    = req_head[IDX_W-1:0];
                  state_next = S_FREE;
                end
              end
            end
            OP_COUNT: begin
              state_next = S_COUNT;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_next.index = rd_data;
        state_next     = S_DONE;
      end
      S_WALK: begin
        priority if (link_end) begin
          tail_next = cur;
          if (op == OP_ALLOC) begin
            state_next = S_SRCH_START;
          end else begin
            res_next.index = LINK_W'(cur);
            state_next     = S_DONE;
          end
        end else if (CMP_W'(steps_inc) >= n_cmp) begin
          res_next.status = ST_LONG;
          state_next      = S_DONE;
        end else if (link_out) begin
          res_next.status = ST_RANGE;
          state_next      = S_DONE;
        end else begin
          cur_next   = rd_data[IDX_W-1:0];
          steps_next = steps_inc;
          rd_addr    = rd_data[IDX_W-1:0];
        end
      end
      S_SRCH_START: begin
        if (n_used <= N_W'(1)) begin
          res_next.status = ST_NOFREE;
          state_next      = S_DONE;
        end else begin
          rd_addr    = IDX_W'(1);
          probe_next = N_W'(1);
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        priority if (rd_data == FREE_MARK) begin
          wr_en          = 1'b1;
          wr_addr        = probe[IDX_W-1:0];
          wr_data        = END_MARK;
          res_next.index = LINK_W'(probe);
          state_next     = head_empty ? S_DONE : S_LINK;
        end else if (CMP_W'(probe_inc) >= n_cmp) begin
          res_next.status = ST_NOFREE;
          state_next      = S_DONE;
        end else begin
          probe_next = probe_inc;
          rd_addr    = probe_inc[IDX_W-1:0];
        end
      end
      S_LINK: begin
        wr_en      = 1'b1;
        wr_addr    = tail;
        wr_data    = res.index;
        state_next = S_DONE;
      end
      S_FREE: begin
        // The entry is cleared while its successor is fetched; the table
        // forwards the clear if the chain loops straight back onto it.
        wr_en   = 1'b1;
        wr_addr = cur;
        wr_data = FREE_MARK;
        priority if (link_end) begin
          state_next = S_DONE;
        end else if (CMP_W'(steps_inc) >= n_cmp) begin
          res_next.status = ST_LONG;
          state_next      = S_DONE;
        end else if (link_out) begin
          res_next.status = ST_RANGE;
          state_next      = S_DONE;
        end else begin
          cur_next   = rd_data[IDX_W-1:0];
          steps_next = steps_inc;
          rd_addr    = rd_data[IDX_W-1:0];
        end
      end
      S_COUNT: begin
        if (CMP_W'(probe_inc) >= n_cmp) begin
          res_next.count = count_inc;
          state_next     = S_DONE;
        end else begin
          count_next = count_inc;
          probe_next = probe_inc;
          rd_addr    = probe_inc[IDX_W-1:0];
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    head_empty <= head_empty_next;
    cur        <= cur_next;
    tail       <= tail_next;
    steps      <= steps_next;
    probe      <= probe_next;
    count      <= count_next;
    res        <= res_next;
  end

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !res_take) |=> (state == S_DONE))
    else $error("finished request left before its result was taken");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state != S_CLEAR) |-> (CMP_W'(wr_addr) < n_cmp))
    else $error("table write outside the entries in use");

  a_nofree_only_alloc: assert property (@(posedge clk) disable iff (rst)
    (done_valid && res.status == ST_NOFREE) |-> (op == OP_ALLOC))
    else $error("no-free status reported for an operation other than allocate");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_FREE) |-> (CMP_W'(steps) < n_cmp))
    else $error("chain walk ran past its step limit");

  a_count_only_count: assert property (@(posedge clk) disable iff (rst)
    (done_valid && op != OP_COUNT) |-> (res.count == '0))
    else $error("free count reported for an operation other than count");

endmodule

>>> src/fat_chain_manager.sv
// ----------------------------------------------------------------------------
// fat_chain_manager
// File allocation table chain manager: write, read, allocate and append,
// find tail, free chain and count free operations on a table of links.
// ----------------------------------------------------------------------------
// After reset the block clears the table (entry 0 becomes the end mark,
// all others free) and accepts no request until that pass is over;
// configuration writes are taken throughout. The table sits in a single
// memory with one read and one write port and registered read data, and
// every operation steps through it one entry per cycle, so the time a
// request takes depends on the data. One request is worked on at a time.
// Each request yields exactly one result, held in an output register so
// that the next request can be taken while the previous result waits to
// be collected. The number of entries in use is data_block_count, with
// zero treated as one and values above TABLE_ENTRIES treated as
// TABLE_ENTRIES.
// ----------------------------------------------------------------------------
module fat_chain_manager
  import fcm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   data_block_count,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    opcode,
  input  logic [LINK_W-1:0]  entry_index,
  input  logic [LINK_W-1:0]  entry_value,
  input  logic [LINK_W-1:0]  chain_head,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LINK_W-1:0]  result_index,
  output logic [CNT_W-1:0]   free_count,
  output logic [ST_W-1:0]    status
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int N_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int N_RESET = (TABLE_ENTRIES < 8192) ? TABLE_ENTRIES : 8192;

  logic [N_W-1:0] n_used;
  logic [N_W-1:0] n_used_next;
  logic           done_valid;
  logic           res_take;
  fcm_result_t    done_res;

  // The count is clamped once, when written, so the sequencer sees only
  // a value between one and the table depth.
  always_comb begin
    priority if (data_block_count == '0) begin
      n_used_next = N_W'(1);
    end else if (CMP_W'(data_block_count) > CMP_W'(TABLE_ENTRIES)) begin
      n_used_next = N_W'(TABLE_ENTRIES);
    end else begin
      n_used_next = N_W'(data_block_count);
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_used <= N_W'(N_RESET);
    end else if (cfg_valid && cfg_ready) begin
      n_used <= n_used_next;
    end
  end

  fcm_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W),
    .N_W           (N_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .n_used     (n_used),
    .req_valid  (in_valid),
    .req_ready  (in_ready),
    .req_op     (opcode),
    .req_index  (entry_index),
    .req_value  (entry_value),
    .req_head   (chain_head),
    .done_valid (done_valid),
    .res_take   (res_take),
    .done_res   (done_res)
  );

  // The output register takes a finished result whenever it is empty or
  // its current result is being collected in the same cycle.
  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && res_take) begin
      result_index <= done_res.index;
      free_count   <= done_res.count;
      status       <= done_res.status;
    end
  end

endmodule

>>> dv/fcm_checker.sv
// ----------------------------------------------------------------------------
// fcm_checker
// Watches the configuration, request and result channels of the chain
// manager, keeps its own copy of the link table and block count, and
// compares every collected result with the oldest predicted one.
// ----------------------------------------------------------------------------
module fcm_checker
  import fcm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CNT_W-1:0]  data_block_count,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [OP_W-1:0]   opcode,
  input  logic [LINK_W-1:0] entry_index,
  input  logic [LINK_W-1:0] entry_value,
  input  logic [LINK_W-1:0] chain_head,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [LINK_W-1:0] result_index,
  input  logic [CNT_W-1:0]  free_count,
  input  logic [ST_W-1:0]   status,
  output int                outstanding,
  output int                mismatches
);

  localparam int COUNT_LIMIT = 2**CNT_W - 1;
  localparam int IDX_W       = $clog2(TABLE_ENTRIES);

  logic [LINK_W-1:0] link_tbl [TABLE_ENTRIES];
  logic [CNT_W-1:0]  cfg_count;
  fcm_result_t       result_q [$];
  int                fail_total = 0;

  // Follows a non-empty chain to its last entry, giving up on a link outside
  // the table in use or once as many links as entries have been followed.
  function automatic logic [ST_W-1:0] walk_to_tail(input logic [LINK_W-1:0] head,
                                                   input int n,
                                                   output logic [LINK_W-1:0] tail);
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nxt;
    int                steps;
    cur   = head;
    steps = 0;
    tail  = '0;
    while (1) begin
      if (cur >= n) return ST_RANGE;
      nxt = link_tbl[cur[IDX_W-1:0]];
      if (nxt == END_MARK) begin
        tail = cur;
        return ST_OK;
      end
      steps++;
      if (steps >= n) return ST_LONG;
      cur = nxt;
    end
  endfunction

  // Carries out one request on the local table and returns its result.
  function automatic fcm_result_t apply_table_op(input logic [OP_W-1:0] op,
                                                 input logic [LINK_W-1:0] idx,
                                                 input logic [LINK_W-1:0] val,
                                                 input logic [LINK_W-1:0] head);
    fcm_result_t       res;
    int                n;
    int                tally;
    int                cleared;
    int                pick;
    logic [LINK_W-1:0] tail;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nxt;
    n = int'(cfg_count);
    if (n < 1) n = 1;
    if (n > TABLE_ENTRIES) n = TABLE_ENTRIES;
    res.index  = END_MARK;
    res.count  = '0;
    res.status = ST_OK;
    case (op)
      OP_WRITE: begin
        if (idx < n) link_tbl[idx[IDX_W-1:0]] = val;
        else res.status = ST_RANGE;
      end
      OP_READ: begin
        if (idx < n) res.index = link_tbl[idx[IDX_W-1:0]];
        else res.status = ST_RANGE;
      end
      OP_ALLOC: begin
        if (head != END_MARK) res.status = walk_to_tail(head, n, tail);
        if (res.status == ST_OK) begin
          pick = 0;
          for (int i = 1; i < n; i++) begin
            if (link_tbl[IDX_W'(i)] == FREE_MARK) begin
              pick = i;
              break;
            end
          end
          if (pick == 0) begin
            res.status = ST_NOFREE;
          end else begin
            link_tbl[IDX_W'(pick)] = END_MARK;
            if (head != END_MARK) link_tbl[tail[IDX_W-1:0]] = LINK_W'(pick);
            res.index = LINK_W'(pick);
          end
        end
      end
      OP_TAIL: begin
        if (head != END_MARK) begin
          res.status = walk_to_tail(head, n, tail);
          if (res.status == ST_OK) res.index = tail;
        end
      end
      OP_FREE: begin
        cur     = head;
        cleared = 0;
        while (cur != END_MARK) begin
          if (cleared >= n) begin
            res.status = ST_LONG;
            break;
          end
          if (cur >= n) begin
            res.status = ST_RANGE;
            break;
          end
          nxt                        = link_tbl[cur[IDX_W-1:0]];
          link_tbl[cur[IDX_W-1:0]] = FREE_MARK;
          cleared++;
          cur = nxt;
        end
      end
      OP_COUNT: begin
        tally = 0;
        for (int i = 0; i < n; i++)
          if (link_tbl[IDX_W'(i)] == FREE_MARK) tally++;
        res.count = CNT_W'((tally > COUNT_LIMIT) ? COUNT_LIMIT : tally);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : track
    fcm_result_t want;
    if (rst) begin
      foreach (link_tbl[i]) link_tbl[i] = FREE_MARK;
      link_tbl[0] = END_MARK;
      cfg_count   = CNT_W'(8192);
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) cfg_count = data_block_count;
      if (in_valid && in_ready)
        result_q.push_back(apply_table_op(opcode, entry_index, entry_value, chain_head));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result index %h count %0d status %0d",
                   $time, result_index, free_count, status);
          fail_total++;
        end else begin
          want = result_q.pop_front();
          if (result_index !== want.index) begin
            $display("%0t: result_index expected %h got %h", $time, want.index, result_index);
            fail_total++;
          end
          if (free_count !== want.count) begin
            $display("%0t: free_count expected %0d got %0d", $time, want.count, free_count);
            fail_total++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, status);
            fail_total++;
          end
        end
      end
    end
    outstanding <= result_q.size();
    mismatches  <= fail_total;
  end

endmodule

>>> dv/tb_fat_chain_manager.sv
// ----------------------------------------------------------------------------
// tb_fat_chain_manager
// Drives the chain manager through a directed run on a tiny table and then
// through random phases at several block counts, with chains loaded by
// write requests and worked on by allocate, tail, free, read and count.
// A checker alongside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_fat_chain_manager;
  import fcm_pkg::*;

  localparam int TABLE_ENTRIES = 8192;
  localparam int CLK_HALF      = 10;
  // The slowest correct run is dominated by the clearing pass after reset
  // and by the large-table phase, where a single allocate can take two full
  // table walks; the limit below is several times that whole budget.
  localparam int TIMEOUT_CYCLES = 2_500_000;
  // Length of the deliberate receiver hold-off that backs up the block.
  localparam int LONG_HOLD     = 300;
  // Longest chain that a random sequence loads with write requests.
  localparam int MAX_CHAIN     = 6;

  // The two opcodes the block treats as no operation.
  localparam logic [OP_W-1:0] OP_NOP_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_NOP_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  data_block_count = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   opcode = '0;
  logic [LINK_W-1:0] entry_index = '0;
  logic [LINK_W-1:0] entry_value = '0;
  logic [LINK_W-1:0] chain_head = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [LINK_W-1:0] result_index;
  logic [CNT_W-1:0]  free_count;
  logic [ST_W-1:0]   status;
  int                outstanding;
  int                mismatches;

  // Idle rates in percent for each side, and the request for a long
  // receiver hold-off, all changed by the stimulus process between phases.
  int   sender_idle_pct   = 13;
  int   receiver_idle_pct = 73;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  fat_chain_manager #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (.*);

  fcm_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) checker_i (.*);

  // The receiver side runs on its own. A hold-off request holds ready low for
  // a long stretch so that the output register fills and the block stops
  // taking requests; otherwise ready follows the current idle rate.
  always @(posedge clk) begin
    if (hold_req) hold_left = LONG_HOLD;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Offers one request, after a random number of idle cycles, and returns on
  // the edge at which it is accepted. Valid is only lowered during a gap, so
  // back-to-back requests keep it high without a second assignment.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [LINK_W-1:0] idx,
                              input logic [LINK_W-1:0] val, input logic [LINK_W-1:0] head);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    entry_index <= idx;
    entry_value <= val;
    chain_head  <= head;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every predicted result has been
  // collected. The first edge lets the checker count the last request.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // The block count is only changed with nothing in flight.
  task automatic write_block_count(input logic [CNT_W-1:0] value);
    cfg_valid        <= 1'b1;
    data_block_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Any 16-bit value, for fields that the operation ignores.
  function automatic logic [LINK_W-1:0] any_link();
    return LINK_W'($urandom());
  endfunction

  // A link value biased towards entries in use, with some end marks, free
  // marks and arbitrary 16-bit values that are mostly out of range.
  function automatic logic [LINK_W-1:0] random_link(input int n);
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return LINK_W'($urandom_range(n - 1));
    if (roll < 75) return END_MARK;
    if (roll < 85) return FREE_MARK;
    return any_link();
  endfunction

  // Random phase on a table of n entries in use. Most of the traffic loads a
  // short chain with write requests, as a mount would, and then works on it
  // with a few requests from its head; the rest are single requests with
  // arbitrary fields, including the unused opcodes.
  task automatic run_random(input int items, input int n);
    logic [LINK_W-1:0] chain_blocks [MAX_CHAIN];
    logic [OP_W-1:0]   op;
    int                sent;
    int                len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 70) begin
        len = $urandom_range(1, (n < MAX_CHAIN) ? n : MAX_CHAIN);
        // Indices may repeat, which leaves loops and crossed chains behind.
        for (int k = 0; k < len; k++) chain_blocks[k] = LINK_W'($urandom_range(n - 1));
        for (int k = 0; k < len; k++) begin
          send_request(OP_WRITE, chain_blocks[k],
                       (k == len - 1) ? END_MARK : chain_blocks[k + 1], any_link());
          sent++;
        end
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(9))
            0, 1, 2: op = OP_ALLOC;
            3, 4:    op = OP_TAIL;
            5, 6:    op = OP_FREE;
            7, 8:    op = OP_READ;
            default: op = OP_COUNT;
          endcase
          send_request(op, chain_blocks[$urandom_range(len - 1)], any_link(),
                       chain_blocks[0]);
          sent++;
        end
      end else begin
        op = OP_W'($urandom_range(7));
        send_request(op, random_link(n), random_link(n), random_link(n));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part on a table of four entries: reads and writes at and past
    // the edge of the table, allocation until the table is full, tail of an
    // empty chain, a chain that loops back on itself, a link that points
    // outside the table, freeing out of range, too long and empty, and the
    // unused opcodes. The block is still clearing its table here, so the
    // first request simply waits for the clearing pass to finish.
    write_block_count(CNT_W'(4));
    send_request(OP_COUNT, any_link(), any_link(), END_MARK);
    send_request(OP_READ,  16'd0,      any_link(), any_link());
    send_request(OP_READ,  16'd3,      any_link(), any_link());
    send_request(OP_READ,  16'd4,      any_link(), any_link());
    send_request(OP_READ,  16'hFFFF,   any_link(), any_link());
    send_request(OP_WRITE, 16'd4,      16'h1234,   any_link());
    send_request(OP_WRITE, 16'hFFFF,   16'hFFFF,   any_link());
    send_request(OP_TAIL,  any_link(), any_link(), 16'd0);
    send_request(OP_ALLOC, any_link(), any_link(), END_MARK);
    send_request(OP_ALLOC, any_link(), any_link(), 16'd1);
    send_request(OP_ALLOC, any_link(), any_link(), 16'd1);
    send_request(OP_ALLOC, any_link(), any_link(), END_MARK);
    send_request(OP_ALLOC, any_link(), any_link(), 16'd1);
    send_request(OP_TAIL,  any_link(), any_link(), 16'd1);
    send_request(OP_TAIL,  any_link(), any_link(), END_MARK);
    send_request(OP_TAIL,  any_link(), any_link(), 16'd4);
    send_request(OP_WRITE, 16'd3,      16'd1,      any_link());
    send_request(OP_TAIL,  any_link(), any_link(), 16'd1);
    send_request(OP_ALLOC, any_link(), any_link(), 16'd1);
    send_request(OP_FREE,  any_link(), any_link(), 16'd4);
    send_request(OP_FREE,  any_link(), any_link(), 16'd1);
    send_request(OP_FREE,  any_link(), any_link(), END_MARK);
    send_request(OP_WRITE, 16'd2,      16'hABCD,   any_link());
    send_request(OP_TAIL,  any_link(), any_link(), 16'd2);
    send_request(OP_WRITE, 16'd1,      16'd0,      16'hFFFF);
    send_request(OP_NOP_LO, any_link(), any_link(), any_link());
    send_request(OP_NOP_HI, any_link(), any_link(), any_link());
    send_request(OP_COUNT, any_link(), any_link(), any_link());
    drain_results();

    // Sender mostly busy, receiver mostly stalling.
    write_block_count(CNT_W'(16));
    run_random(120, 16);
    drain_results();

    // Roles swapped: a register value of zero behaves as a single entry.
    sender_idle_pct   <= 73;
    receiver_idle_pct <= 13;
    write_block_count(CNT_W'(0));
    run_random(30, 1);
    drain_results();
    write_block_count(CNT_W'(37));
    run_random(120, 37);
    drain_results();

    // No idling from here on. The top register value stands for the whole
    // table; this phase is kept short because every walk may cover it all.
    sender_idle_pct   <= 0;
    receiver_idle_pct <= 0;
    write_block_count(CNT_W'(16383));
    run_random(12, TABLE_ENTRIES);
    drain_results();
    write_block_count(CNT_W'(TABLE_ENTRIES));
    run_random(8, TABLE_ENTRIES);
    drain_results();
    write_block_count(CNT_W'(1));
    run_random(20, 1);
    drain_results();

    // Long receiver hold-off while requests keep coming, so that the block
    // fills up and has to stall its input.
    write_block_count(CNT_W'(64));
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_random(120, 64);
    drain_results();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("simulation failed");
    $finish;
  end

endmodule
